### rtl/sitar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitar_pkg: shared types and constants for the integer-to-text converter
// Payload words, the queued job record, radix codes and the digit encoder.
// ----------------------------------------------------------------------------
package sitar_pkg;

    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    // Digit positions per radix, and zero padding above the magnitude
    localparam int BIN_DIGITS = DATA_W;
    localparam int OCT_DIGITS = (DATA_W + 2) / 3;
    localparam int HEX_DIGITS = (DATA_W + 3) / 4;
    localparam int OCT_PAD    = OCT_DIGITS * 3 - DATA_W;
    localparam int HEX_PAD    = HEX_DIGITS * 4 - DATA_W;

    // Shift register is left aligned: the next digit sits in the top bits
    localparam int SH_W  = DATA_W + 4;
    localparam int CNT_W = $clog2(DATA_W + 1);

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic        [1:0]        radix_code;
    } in_word_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       final_char;
    } out_word_t;

    typedef struct packed {
        logic             neg;
        logic [1:0]       radix;
        logic [CNT_W-1:0] ndig;
        logic [SH_W-1:0]  sh;
    } job_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
        begin
            ch = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            ch = CHAR_A + {4'd0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

### rtl/signed_int_to_ascii_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_ascii_radix: signed integer to ASCII text in radix 2, 8, 16
// Front end classifies, a short queue buffers jobs, the back end emits text.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Its text leaves most
// significant character first, one character per strobe cycle: a '-' for a
// negative value, then the digits with leading zeros dropped (zero gives a
// single '0'); final_char marks the last character. Hex letters are uppercase
// and radix code three means hexadecimal. The receiver cannot stall: every
// strobe cycle carries a character that must be taken in that cycle. The
// emitter walks every digit position of the radix one per cycle, after
// the sign state for a negative value: 32 (binary), 11 (octal) or 8 (hex)
// positions. Characters are registered and appear in the cycle after their
// position is examined, and skipped leading zeros produce no strobe. The
// queue of QUEUE_DEPTH jobs lets new words be taken while one is being
// emitted; busy rises only when that queue is full.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_radix
    import sitar_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  operand,
    output logic      busy,
    output logic      strobe,
    output out_word_t result
);

    job_t front_job;
    job_t head_job;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    // take a word only while the queue has room
    assign busy   = q_full;
    assign accept = start && !q_full;

    sitar_front u_front (
        .operand (operand),
        .job     (front_job)
    );

    sitar_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (front_job),
        .pop      (q_pop),
        .pop_job  (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    sitar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (head_job),
        .pop       (q_pop),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

### rtl/sitar_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitar_front: classify an incoming word
// Forms sign and magnitude, aligns the magnitude for the chosen radix.
// ----------------------------------------------------------------------------
module sitar_front
    import sitar_pkg::*;
(
    input  in_word_t operand,
    output job_t     job
);

    logic              neg;
    logic [DATA_W-1:0] mag;
    logic [SH_W-1:0]   mag_ext;

    always_comb
    begin
        neg     = operand.value[DATA_W-1];
        mag     = neg ? (~operand.value + DATA_W'(1)) : operand.value;
        mag_ext = SH_W'(mag);
        job.neg = neg;
        unique case (operand.radix_code)
            RADIX_BIN:
            begin
                job.radix = RADIX_BIN;
                job.ndig  = CNT_W'(BIN_DIGITS);
                job.sh    = mag_ext << (SH_W - DATA_W);
            end
            RADIX_OCT:
            begin
                job.radix = RADIX_OCT;
                job.ndig  = CNT_W'(OCT_DIGITS);
                job.sh    = mag_ext << (SH_W - DATA_W - OCT_PAD);
            end
            default:
            begin
                // hexadecimal, and the unused code treated as hexadecimal
                job.radix = RADIX_HEX;
                job.ndig  = CNT_W'(HEX_DIGITS);
                job.sh    = mag_ext << (SH_W - DATA_W - HEX_PAD);
            end
        endcase
    end

endmodule

### rtl/sitar_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitar_queue: short job queue
// Decouples the front end from the character emitter.
// ----------------------------------------------------------------------------
module sitar_queue
    import sitar_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CNT_QW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/sitar_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitar_back: character emitter
// Emits the sign, then one digit position per cycle, skipping leading zeros.
// ----------------------------------------------------------------------------
module sitar_back
    import sitar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_avail,
    input  job_t      job,
    output logic      pop,
    output logic      strobe,
    output out_word_t result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SIGN  = 2'd1;
    localparam logic [1:0] ST_DIGIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       radix_reg, radix_next;
    logic             started_reg, started_next;
    logic             strobe_reg, strobe_next;
    out_word_t        result_reg, result_next;

    logic [3:0]       digit;
    logic             last_digit;

    always_comb
    begin
        unique case (radix_reg)
            RADIX_BIN: digit = {3'd0, sh_reg[SH_W-1]};
            RADIX_OCT: digit = {1'b0, sh_reg[SH_W-1 -: 3]};
            default:   digit = sh_reg[SH_W-1 -: 4];
        endcase
    end

    assign last_digit = (state_reg == ST_DIGIT) && (cnt_reg == CNT_W'(1));
    assign pop        = job_avail && ((state_reg == ST_IDLE) || last_digit);

    always_comb
    begin
        state_next   = state_reg;
        sh_next      = sh_reg;
        cnt_next     = cnt_reg;
        radix_next   = radix_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;

        unique case (state_reg)
            ST_SIGN:
            begin
                strobe_next            = 1'b1;
                result_next.text_char  = CHAR_MINUS;
                result_next.final_char = 1'b0;
                state_next             = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                // drop leading zeros, but always keep the last position
                if (started_reg || (digit != 4'd0) || last_digit)
                begin
                    strobe_next            = 1'b1;
                    result_next.text_char  = digit_char(digit);
                    result_next.final_char = last_digit;
                    started_next           = 1'b1;
                end
                unique case (radix_reg)
                    RADIX_BIN: sh_next = sh_reg << 1;
                    RADIX_OCT: sh_next = sh_reg << 3;
                    default:   sh_next = sh_reg << 4;
                endcase
                cnt_next = cnt_reg - CNT_W'(1);
                if (last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // load the next job straight away, also on the last digit cycle
        if (pop)
        begin
            sh_next      = job.sh;
            cnt_next     = job.ndig;
            radix_next   = job.radix;
            started_next = 1'b0;
            state_next   = job.neg ? ST_SIGN : ST_DIGIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            strobe_reg  <= strobe_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg     <= sh_next;
        radix_reg  <= radix_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_digit_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (cnt_reg != '0))
        else $error("digit state with no positions left");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |=> (state_reg == ST_DIGIT))
        else $error("sign not followed by digits");

    a_final_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.final_char) |->
            $past((state_reg == ST_DIGIT) && (cnt_reg == CNT_W'(1))))
        else $error("final character not from the last digit position");

    a_sign_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (result_reg.text_char == CHAR_MINUS)) |-> !result_reg.final_char)
        else $error("minus sign flagged as final");

endmodule

### test/sitar_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitar_text_checker: prediction and scoreboard for the integer-to-text block
// Watches the command and character channels, predicts each word's text and
// compares every strobed character against the oldest pending prediction.
// ----------------------------------------------------------------------------
module sitar_text_checker
    import sitar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  operand,
    input  logic      busy,
    input  logic      strobe,
    input  out_word_t result,
    output int        fail_count,
    output int        pending_chars
);

    out_word_t text_pending[$];

    // Build the text of one accepted word, most significant character first
    function automatic void predict_text(input in_word_t w);
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] digit;
        logic              neg;
        int                bits;
        int                ndig;
        out_word_t         ch;
        neg = w.value[DATA_W-1];
        mag = neg ? (~w.value + 1'b1) : w.value;
        case (w.radix_code)
            RADIX_BIN: bits = 1;
            RADIX_OCT: bits = 3;
            default:   bits = 4;
        endcase
        ndig = 1;
        while (ndig * bits < DATA_W && (mag >> (ndig * bits)) != '0)
        begin
            ndig++;
        end
        if (neg)
        begin
            ch.text_char  = CHAR_MINUS;
            ch.final_char = 1'b0;
            text_pending.push_back(ch);
        end
        for (int k = ndig; k > 0; k--)
        begin
            digit = (mag >> ((k - 1) * bits)) & ((1 << bits) - 1);
            if (digit < 10)
            begin
                ch.text_char = CHAR_ZERO + digit[7:0];
            end
            else
            begin
                ch.text_char = CHAR_A + digit[7:0] - 8'd10;
            end
            ch.final_char = (k == 1);
            text_pending.push_back(ch);
        end
    endfunction

    // fail_count and pending_chars are two-state and start at zero
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (text_pending.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected character %h final %b at %0t",
                                 result.text_char, result.final_char, $realtime);
                    end
                    fail_count++;
                end
                else
                begin
                    want = text_pending.pop_front();
                    if (result.text_char !== want.text_char
                        || result.final_char !== want.final_char)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch at %0t: char exp %h got %h, final exp %b got %b",
                                     $realtime, want.text_char, result.text_char,
                                     want.final_char, result.final_char);
                        end
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_text(operand);
            end
            pending_chars = text_pending.size();
        end
    end

endmodule

### test/signed_int_to_ascii_radix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_ascii_radix_tb: stimulus and verdict for the text converter
// Drives directed and random words with bursty idle gaps; the checker beside
// the block predicts and compares every character.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_radix_tb;
    import sitar_pkg::*;

    localparam int RANDOM_WORDS = 400;
    localparam int CALM_TAIL    = 60;      // last words go back to back
    localparam int DRAIN_CYCLES = 40;      // longer than one binary word
    localparam int CYCLE_LIMIT  = 200000;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_word_t  operand;
    logic      busy;
    logic      strobe;
    out_word_t result;
    int        fail_count;
    int        pending_chars;
    int        cycle_count;

    signed_int_to_ascii_radix u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (operand),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    sitar_text_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operand       (operand),
        .busy          (busy),
        .strobe        (strobe),
        .result        (result),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Bound the run: a hung handshake ends here; the counter starts at zero
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one word and hold it until taken; optionally idle afterwards.
    // start is left high so a following word rides on without a gap.
    task automatic send_word(input logic [DATA_W-1:0] v, input logic [1:0] rc,
                             input bit may_idle);
        in_word_t w;
        int       gap;
        w.value      = v;
        w.radix_code = rc;
        operand <= w;
        start   <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mix shapes so that digit counts spread over the whole range: full
    // random, tiny magnitudes, truncated magnitudes, powers of two and runs of ones
    function automatic logic [DATA_W-1:0] random_value();
        logic [DATA_W-1:0] v;
        int                k;
        k = $urandom_range(0, DATA_W - 1);
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 40);
            2: v = -$urandom_range(1, 40);
            3: v = $urandom >> k;
            4: v = -($urandom >> k);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 1 << k;
                    1: v = -(1 << k);
                    2: v = (1 << k) - 1;
                    default: v = -((1 << k) - 1);
                endcase
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [1:0] rc;
        rst_n   = 1'b0;
        start   = 1'b0;
        operand = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, extremes and the most negative value per radix,
        // radix code three as hex, and letters in both halves of the digit set
        for (int r = 0; r < 4; r++)
        begin
            rc = 2'(r);
            send_word(32'h0000_0000, rc, 1'b1);
            send_word(32'h7FFF_FFFF, rc, 1'b0);
            send_word(32'h8000_0000, rc, 1'b1);
            send_word(32'hFFFF_FFFF, rc, 1'b0);
        end
        send_word(32'h0000_0001, RADIX_BIN, 1'b1);
        send_word(32'h0000_0008, RADIX_OCT, 1'b0);
        send_word(32'h0000_000A, RADIX_HEX, 1'b0);
        send_word(32'h0ABC_DEF9, RADIX_HEX, 1'b1);
        send_word(32'hF543_2110, RADIX_HEX, 1'b0);
        send_word(32'h1234_5678, RADIX_OCT, 1'b1);
        send_word(32'hAAAA_AAAA, RADIX_BIN, 1'b0);
        send_word(32'h5555_5555, RADIX_BIN, 1'b1);

        // Random: bursty idling first, then a back-to-back tail that keeps
        // the job queue full and busy asserted
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            rc = 2'($urandom_range(0, 3));
            send_word(random_value(), rc, i < RANDOM_WORDS - CALM_TAIL);
        end
        start <= 1'b0;

        // Drain: wait for every predicted character, then let the emitter
        // settle so stray strobes are caught
        while (pending_chars != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_chars == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/sitar_pkg.sv
rtl/sitar_front.sv
rtl/sitar_queue.sv
rtl/sitar_back.sv
rtl/signed_int_to_ascii_radix.sv
test/sitar_text_checker.sv
test/signed_int_to_ascii_radix_tb.sv
